>>> rtl/ptzcf_pkg.sv
// Package for the PTZ camera command framer: widths, protocol byte codes,
// register indexes, job and handshake structs, and the front-end state type.
// No dependencies.
`default_nettype none

package ptzcf_pkg;

    // Field widths.
    localparam int ANGLE_W = 17;
    localparam int POS_W   = 16;
    localparam int PCT_W   = 7;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 17;

    // Divider geometry: numerator, divisor, remainder, steps of two bits.
    localparam int NUM_W     = 34;
    localparam int DEN_W     = 18;
    localparam int REM_W     = DEN_W + 1;
    localparam int DIV_STEPS = POS_W / 2;
    localparam int DIV_CW    = $clog2(DIV_STEPS);

    // Queue between front and back.
    localparam int Q_DEPTH = 2;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Byte counter within a packet.
    localparam int IDX_W = 4;

    // Command kinds.
    localparam logic [1:0] FUNC_HOME    = 2'd0;
    localparam logic [1:0] FUNC_PANTILT = 2'd1;
    localparam logic [1:0] FUNC_ZOOM    = 2'd2;

    // Register indexes.
    localparam logic [CFG_IW-1:0] REG_PAN_MIN   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_PAN_MAX   = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TILT_MIN  = 3'd2;
    localparam logic [CFG_IW-1:0] REG_TILT_MAX  = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ZOOM_LOW  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_ZOOM_HIGH = 3'd5;

    // Register reset values.
    localparam logic signed [ANGLE_W-1:0] PAN_MIN_RST  = -17'sd43520;
    localparam logic signed [ANGLE_W-1:0] PAN_MAX_RST  = 17'sd43520;
    localparam logic signed [ANGLE_W-1:0] TILT_MIN_RST = -17'sd7680;
    localparam logic signed [ANGLE_W-1:0] TILT_MAX_RST = 17'sd23040;
    localparam logic [POS_W-1:0]          ZOOM_LOW_RST  = 16'd0;
    localparam logic [POS_W-1:0]          ZOOM_HIGH_RST = 16'd16384;

    // Packet byte codes.
    localparam logic [7:0] HDR_BASE       = 8'h80;
    localparam logic [7:0] MSG_COMMAND    = 8'h01;
    localparam logic [7:0] CAT_PANTILT    = 8'h06;
    localparam logic [7:0] CAT_CAMERA     = 8'h04;
    localparam logic [7:0] CMD_HOME       = 8'h04;
    localparam logic [7:0] CMD_ABS_POS    = 8'h02;
    localparam logic [7:0] CMD_ZOOM_DIRECT = 8'h47;
    localparam logic [7:0] TERMINATOR     = 8'hFF;

    // Clamp limits.
    localparam logic [7:0]       ADDR_MAX  = 8'd7;
    localparam logic [7:0]       SPEED_MAX = 8'h18;
    localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
    localparam logic [PCT_W-1:0] PCT_HALF  = 7'd50;

    // Final byte index of each packet.
    localparam logic [IDX_W-1:0] LAST_HOME    = 4'd4;
    localparam logic [IDX_W-1:0] LAST_PANTILT = 4'd14;
    localparam logic [IDX_W-1:0] LAST_ZOOM    = 4'd8;

    // One classified command, ready to be framed.
    typedef struct packed {
        logic [1:0]       func;
        logic [7:0]       head;
        logic [7:0]       pan_speed;
        logic [7:0]       tilt_speed;
        logic [POS_W-1:0] pos_a;
        logic [POS_W-1:0] pos_b;
    } t_job;

    // Front to queue.
    typedef struct packed {
        logic push;
        t_job job;
    } t_qpush;

    // Queue to back.
    typedef struct packed {
        logic empty;
        t_job job;
    } t_qhead;

    // Divider load request.
    typedef struct packed {
        logic             load;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } t_div_req;

    // Divider result.
    typedef struct packed {
        logic             done;
        logic [POS_W-1:0] quo;
    } t_div_rsp;

    typedef enum logic [2:0] {
        F_IDLE,
        F_OFS,
        F_NUM,
        F_DIV,
        F_PUSH
    } t_fstate;

endpackage

`default_nettype wire

>>> rtl/ptzcf_div.sv
// Iterative restoring divider, two quotient bits per cycle, 16-bit quotient.
// Depends on ptzcf_pkg.
`default_nettype none

module ptzcf_div (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ptzcf_pkg::t_div_req i_req,
    output ptzcf_pkg::t_div_rsp      o_rsp
);
    import ptzcf_pkg::*;

    logic [REM_W-1:0]  r_rem;
    logic [POS_W-1:0]  r_low;
    logic [DEN_W-1:0]  r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_run;

    logic [REM_W-1:0] s1, s2, rem1, rem2;
    logic             ge1, ge2;
    logic [POS_W-1:0] low1, low2;

    // Two restoring steps; the low word shifts out numerator bits and in quotient bits.
    always_comb begin
        s1   = {r_rem[REM_W-2:0], r_low[POS_W-1]};
        ge1  = s1 >= {1'b0, r_den};
        rem1 = ge1 ? s1 - {1'b0, r_den} : s1;
        low1 = {r_low[POS_W-2:0], ge1};
        s2   = {rem1[REM_W-2:0], low1[POS_W-1]};
        ge2  = s2 >= {1'b0, r_den};
        rem2 = ge2 ? s2 - {1'b0, r_den} : s2;
        low2 = {low1[POS_W-2:0], ge2};
    end

    // Control: after a load, run until the step counter reaches the last of DIV_STEPS steps.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b0;
            r_cnt <= '0;
        end else if (i_req.load) begin
            r_run <= 1'b1;
            r_cnt <= '0;
        end else if (r_run) begin
            r_cnt <= r_cnt + 1'b1;
            if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                r_run <= 1'b0;
            end
        end
    end

    // Datapath. The upper numerator bits are known to stay below the divisor.
    always_ff @(posedge i_clk) begin
        if (i_req.load) begin
            r_rem <= {1'b0, i_req.num[NUM_W-1:POS_W]};
            r_low <= i_req.num[POS_W-1:0];
            r_den <= i_req.den;
        end else if (r_run) begin
            r_rem <= rem2;
            r_low <= low2;
        end
    end

    assign o_rsp.done = r_run && (r_cnt == DIV_CW'(DIV_STEPS - 1));
    assign o_rsp.quo  = r_low;

endmodule

`default_nettype wire

>>> rtl/ptzcf_front.sv
// Front end: configuration registers, command intake, clamping and position scaling.
// Depends on ptzcf_pkg and ptzcf_div.
`default_nettype none

module ptzcf_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic [1:0]                        i_func,
    input  wire logic [7:0]                        i_cam_address,
    input  wire logic signed [ptzcf_pkg::ANGLE_W-1:0] i_pan_angle,
    input  wire logic signed [ptzcf_pkg::ANGLE_W-1:0] i_tilt_angle,
    input  wire logic [7:0]                        i_pan_rate,
    input  wire logic [7:0]                        i_tilt_rate,
    input  wire logic signed [15:0]                i_zoom_percent,
    input  wire logic                              i_cfg_valid,
    input  wire logic [ptzcf_pkg::CFG_IW-1:0]      i_cfg_index,
    input  wire logic [ptzcf_pkg::CFG_DW-1:0]      i_cfg_data,
    input  wire logic                              i_q_full,
    output ptzcf_pkg::t_qpush                      o_qpush
);
    import ptzcf_pkg::*;

    // Configuration registers.
    logic signed [ANGLE_W-1:0] r_pan_min, r_pan_max, r_tilt_min, r_tilt_max;
    logic [POS_W-1:0]          r_zoom_low, r_zoom_high;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan_min   <= PAN_MIN_RST;
            r_pan_max   <= PAN_MAX_RST;
            r_tilt_min  <= TILT_MIN_RST;
            r_tilt_max  <= TILT_MAX_RST;
            r_zoom_low  <= ZOOM_LOW_RST;
            r_zoom_high <= ZOOM_HIGH_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_PAN_MIN:   r_pan_min   <= $signed(i_cfg_data);
                REG_PAN_MAX:   r_pan_max   <= $signed(i_cfg_data);
                REG_TILT_MIN:  r_tilt_min  <= $signed(i_cfg_data);
                REG_TILT_MAX:  r_tilt_max  <= $signed(i_cfg_data);
                REG_ZOOM_LOW:  r_zoom_low  <= i_cfg_data[POS_W-1:0];
                REG_ZOOM_HIGH: r_zoom_high <= i_cfg_data[POS_W-1:0];
                default: ;
            endcase
        end
    end

    // State machine.
    t_fstate r_state, n_state;
    logic    accept;
    t_div_rsp pan_rsp, tilt_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (start) begin
                    unique case (i_func)
                        FUNC_HOME:    n_state = F_PUSH;
                        FUNC_PANTILT: n_state = F_OFS;
                        FUNC_ZOOM:    n_state = F_OFS;
                        default:      n_state = F_IDLE;
                    endcase
                end
            end
            F_OFS:  n_state = F_NUM;
            F_NUM:  n_state = F_DIV;
            F_DIV: begin
                if (pan_rsp.done && tilt_rsp.done) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    assign busy   = (r_state != F_IDLE);
    assign accept = start && (r_state == F_IDLE);

    // Intake clamps.
    logic [7:0]                c_head, c_ps, c_ts;
    logic signed [ANGLE_W-1:0] c_pan, c_tilt;
    logic [PCT_W-1:0]          c_pct;

    always_comb begin
        if (i_cam_address == 8'd0) begin
            c_head = HDR_BASE | 8'd1;
        end else if (i_cam_address > ADDR_MAX) begin
            c_head = HDR_BASE | ADDR_MAX;
        end else begin
            c_head = HDR_BASE | i_cam_address;
        end

        if (i_pan_rate == 8'd0)          c_ps = 8'd1;
        else if (i_pan_rate > SPEED_MAX) c_ps = SPEED_MAX;
        else                             c_ps = i_pan_rate;

        if (i_tilt_rate == 8'd0)          c_ts = 8'd1;
        else if (i_tilt_rate > SPEED_MAX) c_ts = SPEED_MAX;
        else                              c_ts = i_tilt_rate;

        // Out-of-range angles stick to the nearer end of the range.
        if (i_pan_angle < r_pan_min)      c_pan = r_pan_min;
        else if (i_pan_angle > r_pan_max) c_pan = r_pan_max;
        else                              c_pan = i_pan_angle;

        if (i_tilt_angle < r_tilt_min)      c_tilt = r_tilt_min;
        else if (i_tilt_angle > r_tilt_max) c_tilt = r_tilt_max;
        else                                c_tilt = i_tilt_angle;

        if (i_zoom_percent < 16'sd0) begin
            c_pct = '0;
        end else if (i_zoom_percent > $signed({9'd0, PCT_MAX})) begin
            c_pct = PCT_MAX;
        end else begin
            c_pct = i_zoom_percent[PCT_W-1:0];
        end
    end

    logic [1:0]                r_func;
    logic [7:0]                r_head, r_ps, r_ts;
    logic signed [ANGLE_W-1:0] r_pan_a, r_tilt_a;
    logic [PCT_W-1:0]          r_pct;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func   <= i_func;
            r_head   <= c_head;
            r_ps     <= c_ps;
            r_ts     <= c_ts;
            r_pan_a  <= c_pan;
            r_tilt_a <= c_tilt;
            r_pct    <= c_pct;
        end
    end

    // Offsets, spans and the zoom product.
    logic signed [ANGLE_W:0] pan_sd, tilt_sd, pan_od, tilt_od;
    logic signed [ANGLE_W-1:0] zoom_delta;

    always_comb begin
        pan_sd     = {r_pan_max[ANGLE_W-1], r_pan_max} - {r_pan_min[ANGLE_W-1], r_pan_min};
        tilt_sd    = {r_tilt_max[ANGLE_W-1], r_tilt_max} - {r_tilt_min[ANGLE_W-1], r_tilt_min};
        pan_od     = {r_pan_a[ANGLE_W-1], r_pan_a} - {r_pan_min[ANGLE_W-1], r_pan_min};
        tilt_od    = {r_tilt_a[ANGLE_W-1], r_tilt_a} - {r_tilt_min[ANGLE_W-1], r_tilt_min};
        zoom_delta = $signed({1'b0, r_zoom_high}) - $signed({1'b0, r_zoom_low});
    end

    logic [ANGLE_W-1:0]  r_pan_off, r_pan_span, r_tilt_off, r_tilt_span;
    logic                r_pan_empty, r_tilt_empty;
    logic signed [24:0]  r_zterm;
    logic [22:0]         r_zbase;

    always_ff @(posedge i_clk) begin
        if (r_state == F_OFS) begin
            r_pan_off    <= pan_od[ANGLE_W-1:0];
            r_pan_span   <= pan_sd[ANGLE_W-1:0];
            r_pan_empty  <= pan_sd[ANGLE_W] || (pan_sd == '0);
            r_tilt_off   <= tilt_od[ANGLE_W-1:0];
            r_tilt_span  <= tilt_sd[ANGLE_W-1:0];
            r_tilt_empty <= tilt_sd[ANGLE_W] || (tilt_sd == '0);
            r_zterm      <= zoom_delta * $signed({1'b0, r_pct});
            r_zbase      <= r_zoom_low * PCT_MAX;
        end
    end

    // Numerators: off * 65535 * 2 + span over 2 * span; zoom sum plus 50 over 100.
    logic [NUM_W-1:0]  pan_num, tilt_num, zoom_num;
    logic signed [24:0] zoom_sum;
    t_div_req          pan_req, tilt_req;

    always_comb begin
        pan_num  = {r_pan_off, 17'd0} - {16'd0, r_pan_off, 1'b0}
                 + {17'd0, r_pan_span};
        tilt_num = {r_tilt_off, 17'd0} - {16'd0, r_tilt_off, 1'b0}
                 + {17'd0, r_tilt_span};
        zoom_sum = $signed({2'b00, r_zbase}) + r_zterm + $signed({18'd0, PCT_HALF});
        zoom_num = {11'd0, zoom_sum[22:0]};

        pan_req.load  = (r_state == F_NUM);
        tilt_req.load = (r_state == F_NUM);

        if (r_func == FUNC_ZOOM) begin
            pan_req.num = zoom_num;
            pan_req.den = {11'd0, PCT_MAX};
        end else if (r_pan_empty) begin
            pan_req.num = '0;
            pan_req.den = DEN_W'(1);
        end else begin
            pan_req.num = pan_num;
            pan_req.den = {r_pan_span, 1'b0};
        end

        if (r_tilt_empty) begin
            tilt_req.num = '0;
            tilt_req.den = DEN_W'(1);
        end else begin
            tilt_req.num = tilt_num;
            tilt_req.den = {r_tilt_span, 1'b0};
        end
    end

    ptzcf_div u_pan_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (pan_req),
        .o_rsp   (pan_rsp)
    );

    ptzcf_div u_tilt_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (tilt_req),
        .o_rsp   (tilt_rsp)
    );

    // Hand the classified command to the queue.
    always_comb begin
        o_qpush.push           = (r_state == F_PUSH) && !i_q_full;
        o_qpush.job.func       = r_func;
        o_qpush.job.head       = r_head;
        o_qpush.job.pan_speed  = r_ps;
        o_qpush.job.tilt_speed = r_ts;
        o_qpush.job.pos_a      = pan_rsp.quo;
        o_qpush.job.pos_b      = tilt_rsp.quo;
    end

endmodule

`default_nettype wire

>>> rtl/ptzcf_queue.sv
// Two-entry job queue between the front end and the packet sender.
// Depends on ptzcf_pkg.
`default_nettype none

module ptzcf_queue (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ptzcf_pkg::t_qpush i_qpush,
    output logic                   o_full,
    input  wire logic              i_pop,
    output ptzcf_pkg::t_qhead      o_qhead
);
    import ptzcf_pkg::*;

    t_job            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp, r_rp;
    logic [Q_CW-1:0] r_cnt;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_qpush.push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_qpush.push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_qpush.push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_qpush.push) begin
            r_mem[r_wp] <= i_qpush.job;
        end
    end

    assign o_full        = (r_cnt == Q_CW'(Q_DEPTH));
    assign o_qhead.empty = (r_cnt == '0);
    assign o_qhead.job   = r_mem[r_rp];

endmodule

`default_nettype wire

>>> rtl/ptzcf_back.sv
// Packet sender: walks the bytes of one queued job per packet, one beat a cycle.
// Depends on ptzcf_pkg.
`default_nettype none

module ptzcf_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ptzcf_pkg::t_qhead i_qhead,
    output logic                   o_pop,
    output logic                   o_valid,
    output logic [7:0]             o_packet_byte,
    output logic                   o_last_byte
);
    import ptzcf_pkg::*;

    t_job             r_cur;
    logic [IDX_W-1:0] r_idx;
    logic             r_active;

    logic [7:0]       c_byte;
    logic             c_last;
    logic [IDX_W-1:0] c_last_idx;

    // Byte selection for the current packet position.
    always_comb begin
        unique case (r_cur.func)
            FUNC_PANTILT: c_last_idx = LAST_PANTILT;
            FUNC_ZOOM:    c_last_idx = LAST_ZOOM;
            default:      c_last_idx = LAST_HOME;
        endcase
        c_last = (r_idx == c_last_idx);

        c_byte = TERMINATOR;
        unique case (r_cur.func)
            FUNC_PANTILT: begin
                unique case (r_idx)
                    4'd0:    c_byte = r_cur.head;
                    4'd1:    c_byte = MSG_COMMAND;
                    4'd2:    c_byte = CAT_PANTILT;
                    4'd3:    c_byte = CMD_ABS_POS;
                    4'd4:    c_byte = r_cur.pan_speed;
                    4'd5:    c_byte = r_cur.tilt_speed;
                    4'd6:    c_byte = {4'd0, r_cur.pos_a[15:12]};
                    4'd7:    c_byte = {4'd0, r_cur.pos_a[11:8]};
                    4'd8:    c_byte = {4'd0, r_cur.pos_a[7:4]};
                    4'd9:    c_byte = {4'd0, r_cur.pos_a[3:0]};
                    4'd10:   c_byte = {4'd0, r_cur.pos_b[15:12]};
                    4'd11:   c_byte = {4'd0, r_cur.pos_b[11:8]};
                    4'd12:   c_byte = {4'd0, r_cur.pos_b[7:4]};
                    4'd13:   c_byte = {4'd0, r_cur.pos_b[3:0]};
                    default: c_byte = TERMINATOR;
                endcase
            end
            FUNC_ZOOM: begin
                unique case (r_idx)
                    4'd0:    c_byte = r_cur.head;
                    4'd1:    c_byte = MSG_COMMAND;
                    4'd2:    c_byte = CAT_CAMERA;
                    4'd3:    c_byte = CMD_ZOOM_DIRECT;
                    4'd4:    c_byte = {4'd0, r_cur.pos_a[15:12]};
                    4'd5:    c_byte = {4'd0, r_cur.pos_a[11:8]};
                    4'd6:    c_byte = {4'd0, r_cur.pos_a[7:4]};
                    4'd7:    c_byte = {4'd0, r_cur.pos_a[3:0]};
                    default: c_byte = TERMINATOR;
                endcase
            end
            default: begin
                unique case (r_idx)
                    4'd0:    c_byte = r_cur.head;
                    4'd1:    c_byte = MSG_COMMAND;
                    4'd2:    c_byte = CAT_PANTILT;
                    4'd3:    c_byte = CMD_HOME;
                    default: c_byte = TERMINATOR;
                endcase
            end
        endcase
    end

    // Take the next job when idle or on the last byte of the current one.
    assign o_pop = (!r_active || c_last) && !i_qhead.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            o_valid  <= 1'b0;
        end else begin
            o_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (r_active) begin
                r_idx <= r_idx + 1'b1;
                if (c_last) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    // Job and output beat registers.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_qhead.job;
        end
        o_packet_byte <= c_byte;
        o_last_byte   <= c_last;
    end

endmodule

`default_nettype wire

>>> rtl/ptz_camera_command_framer_top.sv
// Top level of the PTZ camera command framer: front end, job queue, packet sender.
// Depends on ptzcf_pkg, ptzcf_front, ptzcf_queue and ptzcf_back.
//
// Channel   Direction  Handshake                   Payload
// command   in         start high, busy low         func, address, angles, rates, zoom
// config    in         i_cfg_valid & o_cfg_ready    register index, data
// packet    out        o_valid high for each byte   packet byte, last-byte flag
//
// A pan/tilt or zoom command holds the front end from acceptance to hand-off
// through the offset, numerator, divider and push states; home goes straight to push.
// The sender emits one byte per cycle, in packets of 5, 15 or 9 bytes that go out
// back to back while jobs wait in the queue.
// Reset is synchronous; it clears control state and loads the configuration reset values.
// The receiver takes every beat; back pressure stops at the two-entry queue,
// which holds the front end in its push state, with busy high, while it is full.
`default_nettype none

module ptz_camera_command_framer_top (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 start,
    output logic                                      busy,
    input  wire logic [1:0]                           i_func,
    input  wire logic [7:0]                           i_cam_address,
    input  wire logic signed [ptzcf_pkg::ANGLE_W-1:0] i_pan_angle,
    input  wire logic signed [ptzcf_pkg::ANGLE_W-1:0] i_tilt_angle,
    input  wire logic [7:0]                           i_pan_rate,
    input  wire logic [7:0]                           i_tilt_rate,
    input  wire logic signed [15:0]                   i_zoom_percent,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic [ptzcf_pkg::CFG_IW-1:0]         i_cfg_index,
    input  wire logic [ptzcf_pkg::CFG_DW-1:0]         i_cfg_data,
    output logic                                      o_valid,
    output logic [7:0]                                o_packet_byte,
    output logic                                      o_last_byte
);
    import ptzcf_pkg::*;

    t_qpush qpush;
    t_qhead qhead;
    logic   q_full;
    logic   q_pop;

    // Register writes are always taken.
    assign o_cfg_ready = 1'b1;

    ptzcf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_cam_address  (i_cam_address),
        .i_pan_angle    (i_pan_angle),
        .i_tilt_angle   (i_tilt_angle),
        .i_pan_rate     (i_pan_rate),
        .i_tilt_rate    (i_tilt_rate),
        .i_zoom_percent (i_zoom_percent),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_q_full       (q_full),
        .o_qpush        (qpush)
    );

    ptzcf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qpush (qpush),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_qhead (qhead)
    );

    ptzcf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_qhead       (qhead),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .o_packet_byte (o_packet_byte),
        .o_last_byte   (o_last_byte)
    );

endmodule

`default_nettype wire

>>> verif/ptz_camera_command_framer_top_tb.sv
// Self-checking testbench for the PTZ camera command framer: drives command and register
// beats, predicts every packet byte and compares it against the byte stream on the output.
// Depends on ptzcf_pkg and ptz_camera_command_framer_top.
`timescale 1ns / 100ps

module ptz_camera_command_framer_top_tb;
    import ptzcf_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int ANGLE_LIMIT     = 46080;
    localparam int ZOOM_FULL       = 100;
    localparam int DRAIN_CYCLES    = 40;
    localparam int STALL_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int NUM_PHASES      = 5;
    localparam int IDLE_PCT        = 34;

    typedef struct {
        logic [1:0]                func;
        logic [7:0]                addr;
        logic signed [ANGLE_W-1:0] pan;
        logic signed [ANGLE_W-1:0] tilt;
        logic [7:0]                pan_rate;
        logic [7:0]                tilt_rate;
        logic signed [15:0]        zoom_pct;
    } t_cam_cmd;

    typedef struct {
        logic [7:0] data;
        logic       is_last;
    } t_pkt_beat;

    // Packet predictor with its own copy of the range registers.
    class packet_scoreboard;
        longint    pan_lo, pan_hi, tilt_lo, tilt_hi, zoom_lo, zoom_hi;
        t_pkt_beat expected_beats[$];
        int        errors;

        function new();
            pan_lo  = PAN_MIN_RST;
            pan_hi  = PAN_MAX_RST;
            tilt_lo = TILT_MIN_RST;
            tilt_hi = TILT_MAX_RST;
            zoom_lo = ZOOM_LOW_RST;
            zoom_hi = ZOOM_HIGH_RST;
            errors  = 0;
        endfunction

        function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
            case (idx)
                REG_PAN_MIN:   pan_lo  = longint'($signed(data));
                REG_PAN_MAX:   pan_hi  = longint'($signed(data));
                REG_TILT_MIN:  tilt_lo = longint'($signed(data));
                REG_TILT_MAX:  tilt_hi = longint'($signed(data));
                REG_ZOOM_LOW:  zoom_lo = longint'(data[15:0]);
                REG_ZOOM_HIGH: zoom_hi = longint'(data[15:0]);
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // Rounded (a - lo) * 65535 / (hi - lo); an empty range gives zero.
        function logic [15:0] angle_position(longint a, longint lo, longint hi);
            longint span, offs;
            if (hi <= lo) return 16'd0;
            if (a < lo) a = lo;
            if (a > hi) a = hi;
            span = hi - lo;
            offs = a - lo;
            return 16'((offs * 65535 * 2 + span) / (2 * span));
        endfunction

        // Rounded interpolation between the zoom limits, either direction.
        function logic [15:0] zoom_position(longint p);
            if (p < 0) p = 0;
            if (p > ZOOM_FULL) p = ZOOM_FULL;
            return 16'(((ZOOM_FULL - p) * zoom_lo + p * zoom_hi + ZOOM_FULL / 2) / ZOOM_FULL);
        endfunction

        function logic [7:0] clamp_speed(logic [7:0] v);
            if (v == 8'd0) return 8'd1;
            if (v > SPEED_MAX) return SPEED_MAX;
            return v;
        endfunction

        function void push_byte(logic [7:0] b, logic is_last);
            t_pkt_beat beat;
            beat.data    = b;
            beat.is_last = is_last;
            expected_beats = {expected_beats, beat};
        endfunction

        // Position goes out as four nibbles, high nibble first.
        function void push_position(logic [15:0] pos);
            push_byte({4'h0, pos[15:12]}, 1'b0);
            push_byte({4'h0, pos[11:8]}, 1'b0);
            push_byte({4'h0, pos[7:4]}, 1'b0);
            push_byte({4'h0, pos[3:0]}, 1'b0);
        endfunction

        function void note_command(t_cam_cmd c);
            logic [7:0] head;
            head = HDR_BASE | ((c.addr == 8'd0) ? 8'd1 : (c.addr > ADDR_MAX) ? ADDR_MAX : c.addr);
            case (c.func)
                FUNC_HOME: begin
                    push_byte(head, 1'b0);
                    push_byte(MSG_COMMAND, 1'b0);
                    push_byte(CAT_PANTILT, 1'b0);
                    push_byte(CMD_HOME, 1'b0);
                    push_byte(TERMINATOR, 1'b1);
                end
                FUNC_PANTILT: begin
                    push_byte(head, 1'b0);
                    push_byte(MSG_COMMAND, 1'b0);
                    push_byte(CAT_PANTILT, 1'b0);
                    push_byte(CMD_ABS_POS, 1'b0);
                    push_byte(clamp_speed(c.pan_rate), 1'b0);
                    push_byte(clamp_speed(c.tilt_rate), 1'b0);
                    push_position(angle_position(longint'(c.pan), pan_lo, pan_hi));
                    push_position(angle_position(longint'(c.tilt), tilt_lo, tilt_hi));
                    push_byte(TERMINATOR, 1'b1);
                end
                FUNC_ZOOM: begin
                    push_byte(head, 1'b0);
                    push_byte(MSG_COMMAND, 1'b0);
                    push_byte(CAT_CAMERA, 1'b0);
                    push_byte(CMD_ZOOM_DIRECT, 1'b0);
                    push_position(zoom_position(longint'(c.zoom_pct)));
                    push_byte(TERMINATOR, 1'b1);
                end
                // The unused command kind produces no packet.
                default: ;
            endcase
        endfunction

        function void check_beat(logic [7:0] b, logic is_last);
            t_pkt_beat want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat: expected none, got byte %h last %b",
                         $time, b, is_last);
                errors++;
            end else begin
                want = expected_beats.pop_front();
                if (b !== want.data) begin
                    $display("%0t: packet byte mismatch: expected %h, got %h",
                             $time, want.data, b);
                    errors++;
                end
                if (is_last !== want.is_last) begin
                    $display("%0t: last byte flag mismatch: expected %b, got %b",
                             $time, want.is_last, is_last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n;
    logic                      start;
    logic                      busy;
    logic [1:0]                i_func;
    logic [7:0]                i_cam_address;
    logic signed [ANGLE_W-1:0] i_pan_angle;
    logic signed [ANGLE_W-1:0] i_tilt_angle;
    logic [7:0]                i_pan_rate;
    logic [7:0]                i_tilt_rate;
    logic signed [15:0]        i_zoom_percent;
    logic                      i_cfg_valid;
    logic                      o_cfg_ready;
    logic [CFG_IW-1:0]         i_cfg_index;
    logic [CFG_DW-1:0]         i_cfg_data;
    logic                      o_valid;
    logic [7:0]                o_packet_byte;
    logic                      o_last_byte;

    packet_scoreboard sb;
    int               quiet_cycles = 0;

    ptz_camera_command_framer_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_cam_address  (i_cam_address),
        .i_pan_angle    (i_pan_angle),
        .i_tilt_angle   (i_tilt_angle),
        .i_pan_rate     (i_pan_rate),
        .i_tilt_rate    (i_tilt_rate),
        .i_zoom_percent (i_zoom_percent),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_valid        (o_valid),
        .o_packet_byte  (o_packet_byte),
        .o_last_byte    (o_last_byte)
    );

    always #10 i_clk = ~i_clk;

    // Outputs are sampled mid-cycle; a quiet watchdog catches hangs and lost bytes.
    always @(negedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (o_valid === 1'b1) sb.check_beat(o_packet_byte, o_last_byte);
            if ((start && !busy) || o_valid || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Holds one command beat until it is taken; start is left high for a following beat.
    task automatic send_cmd(t_cam_cmd c);
        start          <= 1'b1;
        i_func         <= c.func;
        i_cam_address  <= c.addr;
        i_pan_angle    <= c.pan;
        i_tilt_angle   <= c.tilt;
        i_pan_rate     <= c.pan_rate;
        i_tilt_rate    <= c.tilt_rate;
        i_zoom_percent <= c.zoom_pct;
        forever begin
            @(negedge i_clk);
            if (!busy) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        sb.note_command(c);
    endtask

    // Random sender gaps between command beats.
    task automatic pace(bit enabled);
        if (enabled) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                start <= 1'b0;
                @(posedge i_clk);
            end
        end
    endtask

    task automatic send_fields(logic [1:0] func, int addr, int pan, int tilt,
                               int pan_rate, int tilt_rate, int zoom_pct);
        t_cam_cmd c;
        c.func      = func;
        c.addr      = 8'(addr);
        c.pan       = ANGLE_W'(pan);
        c.tilt      = ANGLE_W'(tilt);
        c.pan_rate  = 8'(pan_rate);
        c.tilt_rate = 8'(tilt_rate);
        c.zoom_pct  = 16'(zoom_pct);
        send_cmd(c);
        pace(1'b1);
    endtask

    // Waits until every predicted byte has come out, then lets the front end drain.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        forever begin
            @(negedge i_clk);
            if (o_cfg_ready) break;
            @(posedge i_clk);
        end
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    // Zoom writes carry a random top bit, which the 16-bit registers drop.
    task automatic apply_config(int pmin, int pmax, int tmin, int tmax, int zlo, int zhi);
        cfg_write(REG_PAN_MIN, CFG_DW'(pmin));
        cfg_write(REG_PAN_MAX, CFG_DW'(pmax));
        cfg_write(REG_TILT_MIN, CFG_DW'(tmin));
        cfg_write(REG_TILT_MAX, CFG_DW'(tmax));
        cfg_write(REG_ZOOM_LOW, {1'($urandom_range(0, 1)), 16'(zlo)});
        cfg_write(REG_ZOOM_HIGH, {1'($urandom_range(0, 1)), 16'(zhi)});
        i_cfg_valid <= 1'b0;
    endtask

    function automatic int rand_full_angle();
        return int'($urandom_range(0, 2 * ANGLE_LIMIT)) - ANGLE_LIMIT;
    endfunction

    // Angles land anywhere, inside the configured range, or right around its ends.
    function automatic int rand_angle(longint lo, longint hi);
        longint a, l, h;
        l = (lo < hi) ? lo : hi;
        h = (lo < hi) ? hi : lo;
        case ($urandom_range(0, 3))
            0: a = rand_full_angle();
            1: a = l + longint'($urandom_range(0, int'(h - l)));
            2: a = l + longint'($urandom_range(0, 4)) - 2;
            default: a = h + longint'($urandom_range(0, 4)) - 2;
        endcase
        if (a < -ANGLE_LIMIT) a = -ANGLE_LIMIT;
        if (a > ANGLE_LIMIT) a = ANGLE_LIMIT;
        return int'(a);
    endfunction

    function automatic t_cam_cmd rand_cmd();
        t_cam_cmd c;
        int       kind;
        kind        = $urandom_range(0, 19);
        c.func      = (kind == 0) ? FUNC_UNUSED : 2'(kind % 3);
        c.addr      = $urandom_range(0, 1) ? 8'($urandom_range(0, 9)) : 8'($urandom_range(0, 255));
        c.pan       = ANGLE_W'(rand_angle(sb.pan_lo, sb.pan_hi));
        c.tilt      = ANGLE_W'(rand_angle(sb.tilt_lo, sb.tilt_hi));
        c.pan_rate  = $urandom_range(0, 1) ? 8'($urandom_range(0, 26)) : 8'($urandom);
        c.tilt_rate = $urandom_range(0, 1) ? 8'($urandom_range(0, 26)) : 8'($urandom);
        c.zoom_pct  = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                  : 16'(int'($urandom_range(0, 110)) - 5);
        return c;
    endfunction

    // Register settings per phase: full ranges, empty and reversed ranges,
    // one-step ranges, then random ones.
    task automatic config_phase(int ph);
        int a, b, c, d;
        case (ph)
            0: apply_config(-ANGLE_LIMIT, ANGLE_LIMIT, -ANGLE_LIMIT, ANGLE_LIMIT, 0, 65535);
            1: apply_config(ANGLE_LIMIT, -ANGLE_LIMIT, 1000, 1000, 65535, 0);
            2: apply_config(-1, 0, ANGLE_LIMIT - 1, ANGLE_LIMIT, 12345, 12346);
            default: begin
                a = rand_full_angle();
                b = rand_full_angle();
                c = rand_full_angle();
                d = rand_full_angle();
                apply_config((a < b) ? a : b, (a < b) ? b : a, (c < d) ? c : d, (c < d) ? d : c,
                             $urandom_range(0, 65535), $urandom_range(0, 65535));
            end
        endcase
    endtask

    initial begin
        sb = new();
        i_rst_n        <= 1'b0;
        start          <= 1'b0;
        i_func         <= FUNC_HOME;
        i_cam_address  <= '0;
        i_pan_angle    <= '0;
        i_tilt_angle   <= '0;
        i_pan_rate     <= '0;
        i_tilt_rate    <= '0;
        i_zoom_percent <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= REG_PAN_MIN;
        i_cfg_data     <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed commands under the reset ranges: address and speed clamps,
        // angles outside and at the range ends, zoom extremes and rounding.
        send_fields(FUNC_HOME, 0, 0, 0, 0, 0, 0);
        send_fields(FUNC_HOME, 7, 0, 0, 0, 0, 0);
        send_fields(FUNC_HOME, 255, 0, 0, 0, 0, 0);
        send_fields(FUNC_PANTILT, 1, -ANGLE_LIMIT, ANGLE_LIMIT, 0, 255, 0);
        send_fields(FUNC_PANTILT, 8, 43520, -7680, 24, 25, 0);
        send_fields(FUNC_PANTILT, 3, 0, 0, 1, 23, 0);
        send_fields(FUNC_PANTILT, 2, 1, -1, 0, 0, 0);
        send_fields(FUNC_PANTILT, 6, ANGLE_LIMIT, -ANGLE_LIMIT, 255, 1, -1);
        send_fields(FUNC_PANTILT, 5, -43520, 23040, 12, 200, 0);
        send_fields(FUNC_ZOOM, 4, 0, 0, 0, 0, -32768);
        send_fields(FUNC_ZOOM, 0, 0, 0, 0, 0, -1);
        send_fields(FUNC_ZOOM, 1, 0, 0, 0, 0, 0);
        send_fields(FUNC_ZOOM, 9, 0, 0, 0, 0, 1);
        send_fields(FUNC_ZOOM, 7, 0, 0, 0, 0, 50);
        send_fields(FUNC_ZOOM, 2, 0, 0, 0, 0, 100);
        send_fields(FUNC_ZOOM, 3, 0, 0, 0, 0, 101);
        send_fields(FUNC_ZOOM, 128, 0, 0, 0, 0, 32767);
        send_fields(FUNC_UNUSED, 5, 0, 0, 0, 0, 0);
        send_fields(FUNC_HOME, 1, 0, 0, 0, 0, 0);

        // Random commands; the first phase runs with no sender gaps at all.
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            config_phase(ph);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                send_cmd(rand_cmd());
                pace(ph != 0);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> ptz_camera_command_framer_top.f
rtl/ptzcf_pkg.sv
rtl/ptzcf_div.sv
rtl/ptzcf_front.sv
rtl/ptzcf_queue.sv
rtl/ptzcf_back.sv
rtl/ptz_camera_command_framer_top.sv
verif/ptz_camera_command_framer_top_tb.sv
